/* rtl/pvh_pkg.sv */
package pvh_pkg;

  localparam int SPECIES    = 16;
  localparam int CELLS      = 4096;
  localparam int COUNT_BITS = 24;
  localparam int SP_BITS    = $clog2(SPECIES);
  localparam int CELL_BITS  = $clog2(CELLS);
  localparam int DEPTH      = SPECIES * CELLS;
  localparam int ADDR_BITS  = SP_BITS + CELL_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    FN_CLEAR       = 2'd0,
    FN_ADD         = 2'd1,
    FN_READ_VOXEL  = 2'd2,
    FN_READ_TOTAL  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    CFG_SIZE_X   = 3'd0,
    CFG_SIZE_Y   = 3'd1,
    CFG_ORIGIN_X = 3'd2,
    CFG_ORIGIN_Y = 3'd3,
    CFG_ORIGIN_Z = 3'd4,
    CFG_SCALE_X  = 3'd5,
    CFG_SCALE_Y  = 3'd6,
    CFG_SCALE_Z  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_MUL0, PH_MUL1, PH_MUL2, PH_EVAL, PH_MULF, PH_SUM
  } idx_phase_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_INDEX, S_READ, S_WB, S_RESP
  } state_t;

  typedef struct packed {
    logic [12:0]        size_x;
    logic [12:0]        size_y;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic [31:0]        scale_x;
    logic [31:0]        scale_y;
    logic [31:0]        scale_z;
  } cfg_t;

  typedef struct packed {
    logic                 done;
    logic                 ok;
    logic [CELL_BITS-1:0] flat;
  } idx_res_t;

  typedef struct packed {
    logic [23:0] count;
    logic [11:0] vidx;
    logic        off;
    logic        ign;
  } res_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

endpackage

/* rtl/pvh_if.sv */
interface pvh_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [4:0]         species;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [11:0]        voxel;
  modport source (output valid, func, species, pos_x, pos_y, pos_z, voxel, input ready);
  modport sink   (input valid, func, species, pos_x, pos_y, pos_z, voxel, output ready);
endinterface

interface pvh_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] count;
  logic [11:0] voxel_index;
  logic        off_grid;
  logic        ignored;
  modport source (output valid, count, voxel_index, off_grid, ignored, input ready);
  modport sink   (input valid, count, voxel_index, off_grid, ignored, output ready);
endinterface

/* rtl/particle_voxel_histogram.sv */
// Per-species voxel histogram of particle positions.
// Input words arrive on in_ch (valid/ready): clear, add particle, read one
// voxel count, read one species total. Each word yields exactly one result
// word on out_ch (valid/ready). Configuration registers are written through
// cfg_we/cfg_index/cfg_data only while the block is idle; the user must keep
// to this, as the block does not enforce it. One item is in flight at a time;
// in_ch.ready is high only when idle. An add runs three axis products
// through one shared 33x32 multiplier, index evaluation, flat-index multiply
// and sum, then a read and write-back of the count memory; an add that falls
// off the grid skips the memory, a voxel read only reads it, and a total read
// or a request with species 0 or out of range goes straight to the result.
// The result word becomes valid in the same cycle that in_ch.ready rises.
// Counts live in one 65536-word memory, so a clear sweeps it one word per
// cycle; after reset the same sweep runs before the first input word is taken.
// The result sits in an output register; when the receiver stalls the block
// still takes and works on the next word, holding its result until the
// register frees up.
module particle_voxel_histogram import pvh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pvh_in_if.sink      in_ch,
  pvh_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  state_t state_r, state_nxt;
  cfg_t   cfg_r;
  logic [COUNT_BITS-1:0] tot_r [SPECIES];
  logic [ADDR_BITS-1:0]  clr_ctr_r, addr_r, addr_nxt;
  logic                  clr_resp_r, is_add_r;
  logic [SP_BITS-1:0]    sp_r;
  logic [11:0]           vidx_r, vidx_nxt;
  res_t                  pend_r, pend_nxt, out_r;
  logic                  out_valid_r;

  logic                  accept, out_free, sp_zero, sp_bad, voxel_ok;
  logic [4:0]            sp_m1;
  logic [SP_BITS-1:0]    in_sp;
  func_t                 in_func;
  logic                  ram_we, ram_re, idx_start, addr_ld, pend_ld;
  logic [ADDR_BITS-1:0]  ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata, new_cnt;
  idx_res_t              idx_res;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_func  = func_t'(in_ch.func);
  assign sp_m1    = in_ch.species - 5'd1;
  assign in_sp    = sp_m1[SP_BITS-1:0];
  assign sp_zero  = (in_ch.species == 5'd0);
  assign sp_bad   = (in_ch.species > 5'(SPECIES));
  assign voxel_ok = ({1'b0, in_ch.voxel} < 13'(CELLS));
  assign new_cnt  = sat_inc(ram_rdata);
  assign in_ch.ready = (state_r == S_IDLE);

  pvh_index u_index (
    .clk   (clk),
    .rst_n (rst_n),
    .start (idx_start),
    .pos_x (in_ch.pos_x),
    .pos_y (in_ch.pos_y),
    .pos_z (in_ch.pos_z),
    .cfg   (cfg_r),
    .res   (idx_res)
  );

  pvh_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (&clr_ctr_r) state_nxt = clr_resp_r ? S_RESP : S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_func == FN_CLEAR) begin
            state_nxt = S_CLEAR;
          end else if (sp_zero || sp_bad) begin
            state_nxt = S_RESP;
          end else begin
            unique case (in_func)
              FN_ADD:        state_nxt = S_INDEX;
              FN_READ_VOXEL: state_nxt = voxel_ok ? S_READ : S_RESP;
              default:       state_nxt = S_RESP;
            endcase
          end
        end
      end
      S_INDEX: if (idx_res.done) state_nxt = idx_res.ok ? S_READ : S_RESP;
      S_READ:  state_nxt = S_WB;
      S_WB:    state_nxt = S_RESP;
      S_RESP:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = new_cnt;
    ram_re    = (state_r == S_READ);
    idx_start = 1'b0;
    addr_ld   = 1'b0;
    addr_nxt  = addr_r;
    vidx_nxt  = vidx_r;
    pend_ld   = 1'b0;
    pend_nxt  = '0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_ctr_r;
        ram_wdata = '0;
        pend_ld   = 1'b1;
      end
      S_IDLE: begin
        if (accept && in_func != FN_CLEAR) begin
          pend_ld = 1'b1;
          if (sp_zero) begin
            pend_nxt.ign = 1'b1;
          end else if (sp_bad) begin
            pend_nxt.off = 1'b1;
          end else begin
            unique case (in_func)
              FN_ADD: idx_start = 1'b1;
              FN_READ_VOXEL: begin
                pend_nxt.off = !voxel_ok;
                addr_ld      = 1'b1;
                addr_nxt     = {in_sp, in_ch.voxel[CELL_BITS-1:0]};
                vidx_nxt     = in_ch.voxel;
              end
              default: pend_nxt.count = 24'(tot_r[in_sp]);
            endcase
          end
        end
      end
      S_INDEX: begin
        if (idx_res.done) begin
          pend_ld      = 1'b1;
          pend_nxt.off = !idx_res.ok;
          addr_ld      = 1'b1;
          addr_nxt     = {sp_r, idx_res.flat};
          vidx_nxt     = 12'(idx_res.flat);
        end
      end
      S_WB: begin
        ram_we         = is_add_r;
        pend_ld        = 1'b1;
        pend_nxt.count = 24'(is_add_r ? new_cnt : ram_rdata);
        pend_nxt.vidx  = vidx_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_ctr_r   <= '0;
      clr_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= '{size_x: 13'd1, size_y: 13'd1, default: '0};
      for (int s = 0; s < SPECIES; s++) tot_r[s] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_ctr_r <= clr_ctr_r + 1'b1;
      if (accept) clr_resp_r <= (in_func == FN_CLEAR);
      if (accept && in_func == FN_CLEAR) begin
        for (int s = 0; s < SPECIES; s++) tot_r[s] <= '0;
      end
      if (state_r == S_WB && is_add_r) tot_r[sp_r] <= sat_inc(tot_r[sp_r]);
      if (state_r == S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_SIZE_X:   cfg_r.size_x   <= cfg_data[12:0];
          CFG_SIZE_Y:   cfg_r.size_y   <= cfg_data[12:0];
          CFG_ORIGIN_X: cfg_r.origin_x <= cfg_data;
          CFG_ORIGIN_Y: cfg_r.origin_y <= cfg_data;
          CFG_ORIGIN_Z: cfg_r.origin_z <= cfg_data;
          CFG_SCALE_X:  cfg_r.scale_x  <= cfg_data;
          CFG_SCALE_Y:  cfg_r.scale_y  <= cfg_data;
          CFG_SCALE_Z:  cfg_r.scale_z  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sp_r     <= in_sp;
      is_add_r <= (in_func == FN_ADD);
    end
    if (addr_ld) begin
      addr_r <= addr_nxt;
      vidx_r <= vidx_nxt;
    end
    if (pend_ld) pend_r <= pend_nxt;
    if (state_r == S_RESP && out_free) out_r <= pend_r;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.count       = out_r.count;
  assign out_ch.voxel_index = out_r.vidx;
  assign out_ch.off_grid    = out_r.off;
  assign out_ch.ignored     = out_r.ign;

  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_WB))
    else $error("count memory written outside clear or write-back");
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result word appeared without a pending response");
  a_idx_done: assert property (@(posedge clk) disable iff (!rst_n)
    idx_res.done |-> state_r == S_INDEX)
    else $error("index unit finished while no add was in flight");
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> state_r == S_CLEAR)
    else $error("reset did not start the clearing sweep");
endmodule

/* rtl/pvh_ram.sv */
module pvh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* rtl/pvh_index.sv */
module pvh_index import pvh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  cfg_t               cfg,
  output idx_res_t           res
);
  idx_phase_t phase_r, phase_nxt;
  logic signed [31:0] pos_r [3];
  logic [63:0] m_r [3];
  logic [2:0]  neg_r;
  logic [12:0] i_r, j_r;
  logic [CELL_BITS-1:0] k_r;
  logic        ok_r;
  logic [CELL_BITS+25:0] t1_r;
  logic [25:0] t2_r;
  logic [25:0] sxy_r;
  idx_res_t    res_r;

  logic [1:0]         ax;
  logic signed [31:0] sel_org;
  logic [31:0]        sel_scale;
  logic [32:0]        d, mag;
  logic [64:0]        prod;
  logic [32:0]        idx [3];
  logic [2:0]         ax_ok;
  logic               i_ok, j_ok, k_ok;
  logic [CELL_BITS+26:0] flat;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: if (start) phase_nxt = PH_MUL0;
      PH_MUL0: phase_nxt = PH_MUL1;
      PH_MUL1: phase_nxt = PH_MUL2;
      PH_MUL2: phase_nxt = PH_EVAL;
      PH_EVAL: phase_nxt = PH_MULF;
      PH_MULF: phase_nxt = PH_SUM;
      PH_SUM:  phase_nxt = PH_IDLE;
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // One shared multiplier walks the three axes.
  always_comb begin
    case (phase_r)
      PH_MUL1: ax = 2'd1;
      PH_MUL2: ax = 2'd2;
      default: ax = 2'd0;
    endcase
    case (ax)
      2'd1:    begin sel_org = cfg.origin_y; sel_scale = cfg.scale_y; end
      2'd2:    begin sel_org = cfg.origin_z; sel_scale = cfg.scale_z; end
      default: begin sel_org = cfg.origin_x; sel_scale = cfg.scale_x; end
    endcase
    d    = {pos_r[ax][31], pos_r[ax]} - {sel_org[31], sel_org};
    mag  = d[32] ? (33'd0 - d) : d;
    prod = 65'(mag) * 65'(sel_scale);
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [64:0] rnd;
      rnd = {1'b0, m_r[a]} + 65'h0_8000_0000;
      if (neg_r[a]) begin
        idx[a]   = '0;
        ax_ok[a] = (m_r[a] <= 64'h8000_0000);
      end else begin
        idx[a]   = rnd[64:32];
        ax_ok[a] = 1'b1;
      end
    end
    i_ok = (idx[0][32:13] == '0) && (idx[0][12:0] < cfg.size_x);
    j_ok = (idx[1][32:13] == '0) && (idx[1][12:0] < cfg.size_y);
    k_ok = (idx[2][32:CELL_BITS] == '0);
    flat = {1'b0, t1_r} + (CELL_BITS+27)'(t2_r) + (CELL_BITS+27)'(i_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      res_r   <= '0;
    end else begin
      phase_r    <= phase_nxt;
      res_r.done <= (phase_r == PH_SUM);
      if (phase_r == PH_SUM) begin
        res_r.ok   <= ok_r && (flat < (CELL_BITS+27)'(CELLS));
        res_r.flat <= flat[CELL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    sxy_r <= 26'(cfg.size_x) * 26'(cfg.size_y);
    if (start && phase_r == PH_IDLE) begin
      pos_r[0] <= pos_x;
      pos_r[1] <= pos_y;
      pos_r[2] <= pos_z;
    end
    if (phase_r == PH_MUL0 || phase_r == PH_MUL1 || phase_r == PH_MUL2) begin
      m_r[ax]   <= prod[63:0];
      neg_r[ax] <= d[32];
    end
    if (phase_r == PH_EVAL) begin
      i_r  <= idx[0][12:0];
      j_r  <= idx[1][12:0];
      k_r  <= idx[2][CELL_BITS-1:0];
      ok_r <= (&ax_ok) && i_ok && j_ok && k_ok;
    end
    if (phase_r == PH_MULF) begin
      t1_r <= (CELL_BITS+26)'(k_r) * (CELL_BITS+26)'(sxy_r);
      t2_r <= 26'(j_r) * 26'(cfg.size_x);
    end
  end

  assign res = res_r;
endmodule

/* test/particle_voxel_histogram_test.sv */
`timescale 1ns / 100ps

module particle_voxel_histogram_test;
  import pvh_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int PHASES         = 6;
  localparam int ITEMS_PER_PHASE = 240;

  typedef struct {
    func_t              func;
    logic [4:0]         species;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [11:0]        voxel;
  } particle_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pvh_in_if  in_if();
  pvh_out_if out_if();

  particle_voxel_histogram u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Local copy of the grid setup and the histogram contents.
  logic [12:0]        grid_sx, grid_sy;
  logic signed [31:0] org_x, org_y, org_z;
  logic [31:0]        scl_x, scl_y, scl_z;
  logic [COUNT_BITS-1:0] bin_count [DEPTH];
  logic [COUNT_BITS-1:0] species_total [SPECIES];

  particle_word_t pending_words[$];
  res_t           expected_bins[$];
  logic [11:0]    hot_voxels[$];
  particle_word_t word_on_bus;

  int errors = 0;
  int idle_mode = 0;
  bit hold_request = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit axis_bin(input logic signed [31:0] p, input logic signed [31:0] o,
                                  input logic [31:0] s, output logic [33:0] idx);
    logic signed [33:0] d;
    logic [32:0]        mag;
    logic [65:0]        m;
    d   = {{2{p[31]}}, p} - {{2{o[31]}}, o};
    mag = d[33] ? 33'(-d) : 33'(d);
    m   = 66'(mag) * 66'(s);
    if (d[33]) begin
      idx = '0;
      return m <= 66'h8000_0000;
    end
    idx = 34'((m + 66'h8000_0000) >> 32);
    return 1'b1;
  endfunction

  // Flat cell index of a particle under the current grid; false when it is dropped.
  function automatic bit locate_cell(input particle_word_t w, output logic [11:0] flat);
    logic [33:0] i, j, k;
    logic [63:0] f;
    bit ok;
    ok = axis_bin(w.pos_x, org_x, scl_x, i);
    ok = axis_bin(w.pos_y, org_y, scl_y, j) && ok;
    ok = axis_bin(w.pos_z, org_z, scl_z, k) && ok;
    flat = '0;
    if (!ok || i >= 34'(grid_sx) || j >= 34'(grid_sy)) return 1'b0;
    f = 64'(k) * 64'(grid_sx) * 64'(grid_sy) + 64'(j) * 64'(grid_sx) + 64'(i);
    if (f >= 64'(CELLS)) return 1'b0;
    flat = f[11:0];
    return 1'b1;
  endfunction

  function automatic res_t histogram_predict(input particle_word_t w);
    res_t r;
    logic [11:0] flat;
    logic [ADDR_BITS-1:0] addr;
    logic [SP_BITS-1:0] sp;
    r = '0;
    sp = SP_BITS'(w.species - 5'd1);
    if (w.func == FN_CLEAR) begin
      foreach (bin_count[n]) bin_count[n] = '0;
      foreach (species_total[n]) species_total[n] = '0;
    end else if (w.species == 5'd0) begin
      r.ign = 1'b1;
    end else if (w.species > 5'(SPECIES)) begin
      r.off = 1'b1;
    end else begin
      case (w.func)
        FN_ADD: begin
          if (locate_cell(w, flat)) begin
            addr = {sp, flat};
            if (bin_count[addr] != CNT_MAX) bin_count[addr] = bin_count[addr] + 1'b1;
            if (species_total[sp] != CNT_MAX) species_total[sp] = species_total[sp] + 1'b1;
            r.count = 24'(bin_count[addr]);
            r.vidx  = flat;
          end else begin
            r.off = 1'b1;
          end
        end
        FN_READ_VOXEL: begin
          r.count = 24'(bin_count[{sp, w.voxel}]);
          r.vidx  = w.voxel;
        end
        default: r.count = 24'(species_total[sp]);
      endcase
    end
    return r;
  endfunction

  // Driver: one word stays on the bus until it is taken.
  always @(posedge clk) begin
    int idle_pct;
    idle_pct = (idle_mode == 0) ? 32 : (idle_mode == 1) ? 71 : 0;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) expected_bins.push_back(histogram_predict(word_on_bus));
      if (!in_if.valid || in_if.ready) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          word_on_bus = pending_words.pop_front();
          in_if.valid   <= 1'b1;
          in_if.func    <= word_on_bus.func;
          in_if.species <= word_on_bus.species;
          in_if.pos_x   <= word_on_bus.pos_x;
          in_if.pos_y   <= word_on_bus.pos_y;
          in_if.pos_z   <= word_on_bus.pos_z;
          in_if.voxel   <= word_on_bus.voxel;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest prediction.
  always @(posedge clk) begin
    int idle_pct;
    res_t e;
    idle_pct = (idle_mode == 0) ? 71 : (idle_mode == 1) ? 32 : 0;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_bins.size() == 0) begin
          $error("result word with no prediction pending");
          errors++;
        end else begin
          e = expected_bins.pop_front();
          if (out_if.count !== e.count) begin
            $error("count expected %0d actual %0d", e.count, out_if.count);
            errors++;
          end
          if (out_if.voxel_index !== e.vidx) begin
            $error("voxel_index expected %0d actual %0d", e.vidx, out_if.voxel_index);
            errors++;
          end
          if (out_if.off_grid !== e.off) begin
            $error("off_grid expected %0d actual %0d", e.off, out_if.off_grid);
            errors++;
          end
          if (out_if.ignored !== e.ign) begin
            $error("ignored expected %0d actual %0d", e.ign, out_if.ignored);
            errors++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_SIZE_X:   grid_sx = val[12:0];
      CFG_SIZE_Y:   grid_sy = val[12:0];
      CFG_ORIGIN_X: org_x = val;
      CFG_ORIGIN_Y: org_y = val;
      CFG_ORIGIN_Z: org_z = val;
      CFG_SCALE_X:  scl_x = val;
      CFG_SCALE_Y:  scl_y = val;
      default:      scl_z = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() > 0 || in_if.valid || expected_bins.size() > 0);
    repeat (20) @(negedge clk);
  endtask

  function automatic particle_word_t make_word(input func_t f, input logic [4:0] sp,
                                               input logic [31:0] px, input logic [31:0] py,
                                               input logic [31:0] pz, input logic [11:0] v);
    particle_word_t w;
    w.func = f; w.species = sp; w.pos_x = px; w.pos_y = py; w.pos_z = pz; w.voxel = v;
    return w;
  endfunction

  // Position that lands near grid point a along an axis of the given origin and scale.
  function automatic logic [31:0] near_point(input logic [31:0] org, input logic [31:0] s,
                                             input int a);
    longint step;
    step = (s == 0) ? 65536 : 64'h1_0000_0000 / s;
    return org + 32'(longint'(a) * step + longint'($urandom_range(0, 32'(step / 2)))
                     - step / 4);
  endfunction

  function automatic int pick_point(input logic [12:0] sz);
    if ($urandom_range(0, 99) < 75) return $urandom_range(0, 3);
    return int'($urandom_range(0, 32'(sz) + 2)) - 1;
  endfunction

  task automatic queue_random_word();
    particle_word_t w;
    logic [11:0] flat;
    int r;
    r = $urandom_range(0, 99);
    w.species = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
                ($urandom_range(0, 1) == 0) ? 5'($urandom_range(1, 2)) :
                5'($urandom_range(1, SPECIES));
    w.voxel = 12'($urandom());
    w.pos_x = $urandom(); w.pos_y = $urandom(); w.pos_z = $urandom();
    if (r < 8) begin
      w.func = func_t'($urandom_range(1, 3));
    end else if (r < 60) begin
      w.func  = FN_ADD;
      w.pos_x = near_point(org_x, scl_x, pick_point(grid_sx));
      w.pos_y = near_point(org_y, scl_y, pick_point(grid_sy));
      w.pos_z = near_point(org_z, scl_z, pick_point(13'd16));
      if (locate_cell(w, flat)) begin
        hot_voxels.push_back(flat);
        if (hot_voxels.size() > 64) void'(hot_voxels.pop_front());
      end
    end else if (r < 85) begin
      w.func = FN_READ_VOXEL;
      if (hot_voxels.size() > 0 && $urandom_range(0, 9) < 6)
        w.voxel = hot_voxels[$urandom_range(0, hot_voxels.size() - 1)];
    end else begin
      w.func = FN_READ_TOTAL;
    end
    pending_words.push_back(w);
  endtask

  task automatic setup_grid(input int p);
    logic [31:0] v [8];
    case (p)
      0: v = '{16, 16, $urandom_range(0, 32'hFFFF) << 8, 32'hFFF0_0000, 0,
               32'h1_0000, 32'h1_0000, 32'h1_0000};
      1: v = '{4096, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000, 0, 32'h1_0000};
      2: v = '{8191, 8191, 32'h7FFF_FFFF, $urandom(), 32'h7FFF_FFFF,
               32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF};
      3: v = '{0, 5, $urandom(), $urandom(), $urandom(), 32'h1_0000, 32'h1_0000, 32'h2_0000};
      4: v = '{13, 7, $urandom_range(0, 32'hFFFF) << 12, $urandom(), 32'h0001_2345,
               32'h1_8000, 32'h0_C000, 32'h2_0000};
      default: v = '{1, 4096, 0, 32'h0010_0000, 32'hFFFF_0000, 0, 32'h1_0000, 32'h1_0000};
    endcase
    for (int n = 0; n < 8; n++) write_reg(cfg_reg_t'(n), v[n]);
  endtask

  initial begin
    in_if.valid = 1'b0; in_if.func = FN_CLEAR; in_if.species = '0;
    in_if.pos_x = '0; in_if.pos_y = '0; in_if.pos_z = '0; in_if.voxel = '0;
    out_if.ready = 1'b0;
    grid_sx = 13'd1; grid_sy = 13'd1;
    org_x = '0; org_y = '0; org_z = '0;
    scl_x = '0; scl_y = '0; scl_z = '0;
    foreach (bin_count[n]) bin_count[n] = '0;
    foreach (species_total[n]) species_total[n] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset grid: one cell, zero scales, so every valid add lands in cell zero.
    pending_words.push_back(make_word(FN_ADD, 1, 0, 0, 0, 0));
    pending_words.push_back(make_word(FN_ADD, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    pending_words.push_back(make_word(FN_ADD, 16, 32'h8000_0000, 32'h7FFF_FFFF,
                                      32'hFFFF_FFFF, 12'hFFF));
    pending_words.push_back(make_word(FN_ADD, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(FN_ADD, 17, 0, 0, 0, 0));
    pending_words.push_back(make_word(FN_ADD, 31, 0, 0, 0, 0));
    pending_words.push_back(make_word(FN_READ_VOXEL, 1, 0, 0, 0, 0));
    pending_words.push_back(make_word(FN_READ_VOXEL, 16, 0, 0, 0, 12'hFFF));
    pending_words.push_back(make_word(FN_READ_VOXEL, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(FN_READ_VOXEL, 31, 0, 0, 0, 0));
    pending_words.push_back(make_word(FN_READ_TOTAL, 1, 0, 0, 0, 0));
    pending_words.push_back(make_word(FN_READ_TOTAL, 16, 0, 0, 0, 0));
    pending_words.push_back(make_word(FN_READ_TOTAL, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(FN_READ_TOTAL, 17, 0, 0, 0, 0));
    pending_words.push_back(make_word(FN_CLEAR, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(FN_READ_TOTAL, 1, 0, 0, 0, 0));
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      idle_mode = p / 2;
      setup_grid(p);
      if (p == 0) begin
        // Rounding edges: half a step below the origin still rounds to zero.
        pending_words.push_back(make_word(FN_ADD, 2, org_x - 32'h8000, org_y, org_z, 0));
        pending_words.push_back(make_word(FN_ADD, 2, org_x - 32'h8001, org_y, org_z, 0));
        pending_words.push_back(make_word(FN_ADD, 2, org_x + 32'h7FFF, org_y, org_z, 0));
        pending_words.push_back(make_word(FN_ADD, 2, org_x + 32'h8000, org_y, org_z, 0));
        pending_words.push_back(make_word(FN_ADD, 2, org_x, org_y, org_z + 32'h10_0000, 0));
      end
      if (p == 1 || p == 4) pending_words.push_back(make_word(FN_CLEAR, 0, 0, 0, 0, 0));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        queue_random_word();
        // The receiver holds off while the sender keeps offering words.
        if (p == 2 && n == 60) begin
          do @(negedge clk); while (pending_words.size() > 0);
          hold_request = 1;
        end
      end
      wait_idle();
      hot_voxels.delete();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
